// ----- rtl/core/fbhfr_pkg.sv -----
package fbhfr_pkg;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PCNT_W  = 6;
    localparam int unsigned INDEX_W = 5;
    localparam int unsigned CFG_A_W = 3;

    // compare width for lengths: payload_count is 6 bits
    localparam int unsigned CMP_W = 7;

    // default staging depth
    localparam int unsigned MAX_PAYLOAD_DEF = 32;

    // register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST    = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST   = 8'h00;
    localparam logic [BYTE_W-1:0] FRAME_IDENT_RST   = 8'h04;
    localparam logic [BYTE_W-1:0] LENGTH_CODE_RST   = 8'd28;
    localparam logic [PCNT_W-1:0] PAYLOAD_COUNT_RST = 6'd28;
    localparam logic [BYTE_W-1:0] TAIL_FIRST_RST    = 8'h00;
    localparam logic [BYTE_W-1:0] TAIL_SECOND_RST   = 8'hAA;

    // parser phases
    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_SYNC1 = 3'd1,
        PH_SYNC2 = 3'd2,
        PH_IDENT = 3'd3,
        PH_DATA  = 3'd4,
        PH_TAIL1 = 3'd5
    } t_phase;

    // configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_SYNC_FIRST    = 3'd0,
        CFG_SYNC_SECOND   = 3'd1,
        CFG_FRAME_IDENT   = 3'd2,
        CFG_LENGTH_CODE   = 3'd3,
        CFG_PAYLOAD_COUNT = 3'd4,
        CFG_TAIL_FIRST    = 3'd5,
        CFG_TAIL_SECOND   = 3'd6
    } t_cfg_idx;

endpackage

// ----- rtl/core/four_byte_header_frame_receiver.sv -----
// Frame receiver for a byte stream: sync one, sync two, frame id, length code,
// a configured number of payload bytes, then tail one and tail two.
// Input channel: one received byte per beat (i_in_valid / o_in_ready).
// Output channel: one payload byte per beat with its index and a last flag
// (o_out_valid / i_out_ready), given only once the second tail byte matches.
// Config channel: register index and data (i_cfg_valid / o_cfg_ready), always
// ready; write only while no frame is in progress and the output is drained.
// Throughput: one input byte per cycle unless the input stalls. The payload
// sits in a two-bank staging memory, so a new frame fills one bank while the
// last good frame is read out of the other at one beat per cycle unless held.
// Read-out: after the commit, each byte passes the memory read and output registers;
// beats come one per cycle while the output is not held.
// Stall: a held output holds the two-stage read pipeline once stage one is full.
// Input stalls only while the parser waits for the second tail byte and the
// previous frame is still being read out of its bank, until its last read is issued.
// Reset: parser goes idle, registers take their defaults, output and read-out
// state are cleared. Staging memory is not cleared; only bytes written by the
// frame being committed are ever read.
module four_byte_header_frame_receiver #(
    parameter int unsigned MAX_PAYLOAD = fbhfr_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fbhfr_pkg::CFG_A_W-1:0]    i_cfg_index,
    input  logic [fbhfr_pkg::BYTE_W-1:0]     i_cfg_data,
    // received bytes
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [fbhfr_pkg::BYTE_W-1:0]     i_rx_byte,
    // committed payload
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [fbhfr_pkg::BYTE_W-1:0]     o_payload_byte,
    output logic [fbhfr_pkg::INDEX_W-1:0]    o_byte_index,
    output logic                             o_last_byte
);

    localparam int unsigned IDX_W  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned ADDR_W = IDX_W + 1;
    localparam int unsigned DEPTH  = 2 ** ADDR_W;
    localparam int unsigned CMP_W  = fbhfr_pkg::CMP_W;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_PAYLOAD);

    // configuration registers
    logic [fbhfr_pkg::BYTE_W-1:0] r_sync_first;
    logic [fbhfr_pkg::BYTE_W-1:0] r_sync_second;
    logic [fbhfr_pkg::BYTE_W-1:0] r_frame_ident;
    logic [fbhfr_pkg::BYTE_W-1:0] r_length_code;
    logic [fbhfr_pkg::PCNT_W-1:0] r_payload_count;
    logic [fbhfr_pkg::BYTE_W-1:0] r_tail_first;
    logic [fbhfr_pkg::BYTE_W-1:0] r_tail_second;

    // parser state
    fbhfr_pkg::t_phase r_phase, n_phase;
    logic [CNT_W-1:0]  r_stored_count, n_stored_count;
    logic              r_wr_bank, n_wr_bank;

    // read-out state
    logic              r_drain_active, n_drain_active;
    logic              r_drain_bank, n_drain_bank;
    logic [IDX_W-1:0]  r_drain_idx, n_drain_idx;
    logic [CNT_W-1:0]  r_drain_len, n_drain_len;

    // read pipeline: stage one holds the memory read, stage two the output
    logic                            r_s1_valid;
    logic [fbhfr_pkg::INDEX_W-1:0]   r_s1_index;
    logic                            r_s1_last;
    logic [fbhfr_pkg::BYTE_W-1:0]    r_rd_data;
    logic                            r_out_valid;
    logic [fbhfr_pkg::BYTE_W-1:0]    r_payload_byte;
    logic [fbhfr_pkg::INDEX_W-1:0]   r_byte_index;
    logic                            r_last_byte;

    // staging memory, two banks of 2**IDX_W bytes, at least MAX_PAYLOAD each
    logic [fbhfr_pkg::BYTE_W-1:0] r_mem [0:DEPTH-1];

    logic              in_fire;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ADDR_W-1:0] mem_raddr;
    logic              adv_out;
    logic              adv_s1;
    logic              rd_issue;
    logic [CNT_W-1:0]  drain_next;
    logic              drain_last;
    logic [CMP_W-1:0]  eff_len;
    logic [CMP_W-1:0]  cnt_cmp;
    logic [CMP_W-1:0]  idx_wide;

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !((r_phase == fbhfr_pkg::PH_TAIL1) && r_drain_active);
    assign in_fire     = i_in_valid && o_in_ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_first    <= fbhfr_pkg::SYNC_FIRST_RST;
            r_sync_second   <= fbhfr_pkg::SYNC_SECOND_RST;
            r_frame_ident   <= fbhfr_pkg::FRAME_IDENT_RST;
            r_length_code   <= fbhfr_pkg::LENGTH_CODE_RST;
            r_payload_count <= fbhfr_pkg::PAYLOAD_COUNT_RST;
            r_tail_first    <= fbhfr_pkg::TAIL_FIRST_RST;
            r_tail_second   <= fbhfr_pkg::TAIL_SECOND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (fbhfr_pkg::t_cfg_idx'(i_cfg_index))
                fbhfr_pkg::CFG_SYNC_FIRST:    r_sync_first    <= i_cfg_data;
                fbhfr_pkg::CFG_SYNC_SECOND:   r_sync_second   <= i_cfg_data;
                fbhfr_pkg::CFG_FRAME_IDENT:   r_frame_ident   <= i_cfg_data;
                fbhfr_pkg::CFG_LENGTH_CODE:   r_length_code   <= i_cfg_data;
                fbhfr_pkg::CFG_PAYLOAD_COUNT:
                    r_payload_count <= i_cfg_data[fbhfr_pkg::PCNT_W-1:0];
                fbhfr_pkg::CFG_TAIL_FIRST:    r_tail_first    <= i_cfg_data;
                fbhfr_pkg::CFG_TAIL_SECOND:   r_tail_second   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // payload length, clipped to MAX_PAYLOAD
    assign cnt_cmp = CMP_W'(r_stored_count);
    always_comb begin
        eff_len = CMP_W'(r_payload_count);
        if (eff_len > MAX_LEN) begin
            eff_len = MAX_LEN;
        end
    end

    // read pipeline enables
    assign adv_out    = !r_out_valid || i_out_ready;
    assign adv_s1     = adv_out || !r_s1_valid;
    assign rd_issue   = r_drain_active && adv_s1;
    assign drain_next = CNT_W'(r_drain_idx) + CNT_W'(1);
    assign drain_last = (drain_next == r_drain_len);
    assign idx_wide   = CMP_W'(r_drain_idx);
    assign mem_raddr  = {r_drain_bank, r_drain_idx};
    assign mem_waddr  = {r_wr_bank, r_stored_count[IDX_W-1:0]};

    // parser and read-out next state
    always_comb begin
        n_phase        = r_phase;
        n_stored_count = r_stored_count;
        n_wr_bank      = r_wr_bank;
        n_drain_active = r_drain_active;
        n_drain_bank   = r_drain_bank;
        n_drain_idx    = r_drain_idx;
        n_drain_len    = r_drain_len;
        mem_we         = 1'b0;

        // step through a bank already committed
        if (rd_issue) begin
            n_drain_idx = drain_next[IDX_W-1:0];
            if (drain_last) begin
                n_drain_active = 1'b0;
            end
        end

        if (in_fire) begin
            case (r_phase)
                fbhfr_pkg::PH_SYNC1: begin
                    n_phase = (i_rx_byte == r_sync_second) ? fbhfr_pkg::PH_SYNC2
                                                           : fbhfr_pkg::PH_IDLE;
                end
                fbhfr_pkg::PH_SYNC2: begin
                    n_phase = (i_rx_byte == r_frame_ident) ? fbhfr_pkg::PH_IDENT
                                                           : fbhfr_pkg::PH_IDLE;
                end
                fbhfr_pkg::PH_IDENT: begin
                    n_phase = (i_rx_byte == r_length_code) ? fbhfr_pkg::PH_DATA
                                                           : fbhfr_pkg::PH_IDLE;
                    n_stored_count = '0;
                end
                fbhfr_pkg::PH_DATA: begin
                    if (cnt_cmp < eff_len) begin
                        mem_we         = 1'b1;
                        n_stored_count = r_stored_count + CNT_W'(1);
                    end else if (i_rx_byte == r_tail_first) begin
                        n_phase = fbhfr_pkg::PH_TAIL1;
                    end else begin
                        n_phase        = fbhfr_pkg::PH_IDLE;
                        n_stored_count = '0;
                    end
                end
                fbhfr_pkg::PH_TAIL1: begin
                    // commit: hand the filled bank to the read-out side
                    if ((i_rx_byte == r_tail_second) && (r_stored_count != '0)) begin
                        n_drain_active = 1'b1;
                        n_drain_bank   = r_wr_bank;
                        n_drain_idx    = '0;
                        n_drain_len    = r_stored_count;
                        n_wr_bank      = !r_wr_bank;
                    end
                    n_phase        = fbhfr_pkg::PH_IDLE;
                    n_stored_count = '0;
                end
                default: begin
                    n_phase = (i_rx_byte == r_sync_first) ? fbhfr_pkg::PH_SYNC1
                                                          : fbhfr_pkg::PH_IDLE;
                    n_stored_count = '0;
                end
            endcase
        end
    end

    // parser and read-out registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= fbhfr_pkg::PH_IDLE;
            r_stored_count <= '0;
            r_wr_bank      <= 1'b0;
            r_drain_active <= 1'b0;
            r_drain_bank   <= 1'b0;
            r_drain_idx    <= '0;
            r_drain_len    <= '0;
        end else begin
            r_phase        <= n_phase;
            r_stored_count <= n_stored_count;
            r_wr_bank      <= n_wr_bank;
            r_drain_active <= n_drain_active;
            r_drain_bank   <= n_drain_bank;
            r_drain_idx    <= n_drain_idx;
            r_drain_len    <= n_drain_len;
        end
    end

    // staging memory write
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_rx_byte;
        end
    end

    // stage one: registered memory read
    always_ff @(posedge i_clk) begin
        if (adv_s1) begin
            r_rd_data  <= r_mem[mem_raddr];
            r_s1_index <= idx_wide[fbhfr_pkg::INDEX_W-1:0];
            r_s1_last  <= drain_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv_s1) begin
            r_s1_valid <= rd_issue;
        end
    end

    // stage two: output register
    always_ff @(posedge i_clk) begin
        if (adv_out) begin
            r_payload_byte <= r_rd_data;
            r_byte_index   <= r_s1_index;
            r_last_byte    <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_payload_byte;
    assign o_byte_index   = r_byte_index;
    assign o_last_byte    = r_last_byte;

endmodule

// ----- tb/tb_four_byte_header_frame_receiver.sv -----
`timescale 1ns / 100ps

module tb_four_byte_header_frame_receiver;

    localparam int STAGE_DEPTH    = fbhfr_pkg::MAX_PAYLOAD_DEF;
    localparam int CYCLE_LIMIT    = 200000;
    // margin for the output to show after the committing beat
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLDOFF_CYCLES = 400;

    // how a generated frame is spoilt, if at all
    typedef enum int {
        FR_GOOD,
        FR_BAD_SYNC2,
        FR_BAD_IDENT,
        FR_BAD_LENGTH,
        FR_BAD_TAIL1,
        FR_BAD_TAIL2
    } t_frame_kind;

    typedef struct packed {
        logic [fbhfr_pkg::BYTE_W-1:0]  data;
        logic [fbhfr_pkg::INDEX_W-1:0] index;
        logic                          is_last;
    } t_payload_beat;

    // block ports
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [fbhfr_pkg::CFG_A_W-1:0]   i_cfg_index = fbhfr_pkg::CFG_SYNC_FIRST;
    logic [fbhfr_pkg::BYTE_W-1:0]    i_cfg_data  = '0;
    logic                            i_in_valid  = 1'b0;
    logic                            o_in_ready;
    logic [fbhfr_pkg::BYTE_W-1:0]    i_rx_byte   = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [fbhfr_pkg::BYTE_W-1:0]    o_payload_byte;
    logic [fbhfr_pkg::INDEX_W-1:0]   o_byte_index;
    logic                            o_last_byte;

    // stimulus and scoreboard state
    logic [fbhfr_pkg::BYTE_W-1:0]    rx_bytes_q [$];
    t_payload_beat                   pending_beats [$];
    int                              pushed_cnt     = 0;
    int                              accepted_cnt   = 0;
    int                              beat_cnt       = 0;
    int                              frame_cnt      = 0;
    int                              cfg_write_cnt  = 0;
    int                              error_cnt      = 0;
    int                              cycle_cnt      = 0;
    int                              send_idle_pct  = 0;
    int                              recv_stall_pct = 0;
    logic                            rx_hold        = 1'b0;
    logic                            holdoff_req    = 1'b0;
    logic                            holdoff_done   = 1'b0;
    int                              holdoff_cnt    = 0;
    logic                            in_taken       = 1'b0;
    logic                            cfg_taken      = 1'b0;
    logic [fbhfr_pkg::BYTE_W-1:0]    gen_cfg [7];

    // predicted parser state and register copies
    logic [fbhfr_pkg::BYTE_W-1:0]    cur_sync_first;
    logic [fbhfr_pkg::BYTE_W-1:0]    cur_sync_second;
    logic [fbhfr_pkg::BYTE_W-1:0]    cur_frame_ident;
    logic [fbhfr_pkg::BYTE_W-1:0]    cur_length_code;
    logic [fbhfr_pkg::PCNT_W-1:0]    cur_payload_count;
    logic [fbhfr_pkg::BYTE_W-1:0]    cur_tail_first;
    logic [fbhfr_pkg::BYTE_W-1:0]    cur_tail_second;
    fbhfr_pkg::t_phase               rx_phase;
    logic [fbhfr_pkg::PCNT_W-1:0]    stored_cnt;
    logic [fbhfr_pkg::BYTE_W-1:0]    staging [STAGE_DEPTH];

    four_byte_header_frame_receiver #(
        .MAX_PAYLOAD(STAGE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_payload_byte (o_payload_byte),
        .o_byte_index   (o_byte_index),
        .o_last_byte    (o_last_byte)
    );

    always #10 i_clk = ~i_clk;

    task report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_cnt++;
    endtask

    // advance the frame parser by one received byte, queue any committed payload
    task parse_rx_byte(input logic [fbhfr_pkg::BYTE_W-1:0] b);
        int            lim;
        int            n;
        t_payload_beat beat;
        lim = (cur_payload_count > STAGE_DEPTH) ? STAGE_DEPTH : int'(cur_payload_count);
        case (rx_phase)
            fbhfr_pkg::PH_SYNC1: begin
                rx_phase = (b == cur_sync_second) ? fbhfr_pkg::PH_SYNC2 : fbhfr_pkg::PH_IDLE;
            end
            fbhfr_pkg::PH_SYNC2: begin
                rx_phase = (b == cur_frame_ident) ? fbhfr_pkg::PH_IDENT : fbhfr_pkg::PH_IDLE;
            end
            fbhfr_pkg::PH_IDENT: begin
                rx_phase   = (b == cur_length_code) ? fbhfr_pkg::PH_DATA : fbhfr_pkg::PH_IDLE;
                stored_cnt = '0;
            end
            fbhfr_pkg::PH_DATA: begin
                if (stored_cnt < lim) begin
                    staging[stored_cnt % STAGE_DEPTH] = b;
                    stored_cnt = stored_cnt + 1'b1;
                end else if (b == cur_tail_first) begin
                    rx_phase = fbhfr_pkg::PH_TAIL1;
                end else begin
                    rx_phase   = fbhfr_pkg::PH_IDLE;
                    stored_cnt = '0;
                end
            end
            fbhfr_pkg::PH_TAIL1: begin
                // second tail commits whatever was actually stored
                if (b == cur_tail_second) begin
                    n = (stored_cnt > STAGE_DEPTH) ? STAGE_DEPTH : int'(stored_cnt);
                    for (int k = 0; k < n; k++) begin
                        beat.data    = staging[k];
                        beat.index   = k[fbhfr_pkg::INDEX_W-1:0];
                        beat.is_last = (k + 1 == n);
                        pending_beats.push_back(beat);
                    end
                    if (n > 0) frame_cnt++;
                end
                rx_phase   = fbhfr_pkg::PH_IDLE;
                stored_cnt = '0;
            end
            default: begin
                rx_phase   = (b == cur_sync_first) ? fbhfr_pkg::PH_SYNC1 : fbhfr_pkg::PH_IDLE;
                stored_cnt = '0;
            end
        endcase
    endtask

    // monitor: payload beats, accepted bytes and register writes
    always @(posedge i_clk) begin
        t_payload_beat want;
        cycle_cnt++;
        in_taken  <= i_in_valid && o_in_ready;
        cfg_taken <= i_cfg_valid && o_cfg_ready;
        if (!i_rst_n) begin
            cur_sync_first    = fbhfr_pkg::SYNC_FIRST_RST;
            cur_sync_second   = fbhfr_pkg::SYNC_SECOND_RST;
            cur_frame_ident   = fbhfr_pkg::FRAME_IDENT_RST;
            cur_length_code   = fbhfr_pkg::LENGTH_CODE_RST;
            cur_payload_count = fbhfr_pkg::PAYLOAD_COUNT_RST;
            cur_tail_first    = fbhfr_pkg::TAIL_FIRST_RST;
            cur_tail_second   = fbhfr_pkg::TAIL_SECOND_RST;
            rx_phase          = fbhfr_pkg::PH_IDLE;
            stored_cnt        = '0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                beat_cnt++;
                if (pending_beats.size() == 0) begin
                    report_error($sformatf("payload beat 0x%02h index %0d with nothing pending",
                                           o_payload_byte, o_byte_index));
                end else begin
                    want = pending_beats.pop_front();
                    if (o_payload_byte !== want.data)
                        report_error($sformatf("payload byte 0x%02h, wanted 0x%02h",
                                               o_payload_byte, want.data));
                    if (o_byte_index !== want.index)
                        report_error($sformatf("byte index %0d, wanted %0d",
                                               o_byte_index, want.index));
                    if (o_last_byte !== want.is_last)
                        report_error($sformatf("last flag %0b, wanted %0b at index %0d",
                                               o_last_byte, want.is_last, want.index));
                end
            end
            // a byte taken at this edge still sees the old register values
            if (i_in_valid && o_in_ready) begin
                accepted_cnt++;
                parse_rx_byte(i_rx_byte);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_write_cnt++;
                case (i_cfg_index)
                    fbhfr_pkg::CFG_SYNC_FIRST:    cur_sync_first    = i_cfg_data;
                    fbhfr_pkg::CFG_SYNC_SECOND:   cur_sync_second   = i_cfg_data;
                    fbhfr_pkg::CFG_FRAME_IDENT:   cur_frame_ident   = i_cfg_data;
                    fbhfr_pkg::CFG_LENGTH_CODE:   cur_length_code   = i_cfg_data;
                    fbhfr_pkg::CFG_PAYLOAD_COUNT:
                        cur_payload_count = i_cfg_data[fbhfr_pkg::PCNT_W-1:0];
                    fbhfr_pkg::CFG_TAIL_FIRST:    cur_tail_first    = i_cfg_data;
                    fbhfr_pkg::CFG_TAIL_SECOND:   cur_tail_second   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still pending",
                     cycle_cnt, pending_beats.size());
            $display("FAILURE");
            $finish;
        end
    end

    // byte driver: holds a beat until taken, idles at random between beats
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_rx_byte  <= rx_bytes_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // sink hold-off: once requested, holds the sink for a counted stretch
    always @(posedge i_clk) begin
        if (rx_hold) begin
            holdoff_cnt <= holdoff_cnt + 1;
            if (holdoff_cnt == HOLDOFF_CYCLES - 1) begin
                rx_hold      <= 1'b0;
                holdoff_done <= 1'b1;
            end
        end else if (holdoff_req && !holdoff_done) begin
            rx_hold     <= 1'b1;
            holdoff_cnt <= 0;
        end
    end

    // payload sink: random stalls, or a long hold-off
    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n && !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [fbhfr_pkg::BYTE_W-1:0] differ_from(
        input logic [fbhfr_pkg::BYTE_W-1:0] v
    );
        return v ^ (8'h01 << $urandom_range(7));
    endfunction

    function automatic int gen_eff_len();
        return (gen_cfg[fbhfr_pkg::CFG_PAYLOAD_COUNT] > STAGE_DEPTH)
               ? STAGE_DEPTH : int'(gen_cfg[fbhfr_pkg::CFG_PAYLOAD_COUNT]);
    endfunction

    task push_rx(input logic [fbhfr_pkg::BYTE_W-1:0] b);
        rx_bytes_q.push_back(b);
        pushed_cnt++;
    endtask

    // one frame with the current settings; fill below zero means random payload
    task push_frame(input t_frame_kind kind, input int fill);
        int n;
        n = gen_eff_len();
        push_rx(gen_cfg[fbhfr_pkg::CFG_SYNC_FIRST]);
        if (kind == FR_BAD_SYNC2) begin
            push_rx(differ_from(gen_cfg[fbhfr_pkg::CFG_SYNC_SECOND]));
            return;
        end
        push_rx(gen_cfg[fbhfr_pkg::CFG_SYNC_SECOND]);
        if (kind == FR_BAD_IDENT) begin
            push_rx(differ_from(gen_cfg[fbhfr_pkg::CFG_FRAME_IDENT]));
            return;
        end
        push_rx(gen_cfg[fbhfr_pkg::CFG_FRAME_IDENT]);
        if (kind == FR_BAD_LENGTH) begin
            push_rx(differ_from(gen_cfg[fbhfr_pkg::CFG_LENGTH_CODE]));
            return;
        end
        push_rx(gen_cfg[fbhfr_pkg::CFG_LENGTH_CODE]);
        repeat (n) push_rx((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
        if (kind == FR_BAD_TAIL1) begin
            push_rx(differ_from(gen_cfg[fbhfr_pkg::CFG_TAIL_FIRST]));
            return;
        end
        push_rx(gen_cfg[fbhfr_pkg::CFG_TAIL_FIRST]);
        push_rx((kind == FR_BAD_TAIL2) ? differ_from(gen_cfg[fbhfr_pkg::CFG_TAIL_SECOND])
                                       : gen_cfg[fbhfr_pkg::CFG_TAIL_SECOND]);
    endtask

    // write every register, one beat each, while the block is idle
    task write_regs(input logic [fbhfr_pkg::BYTE_W-1:0] s1, s2, fid, lcode, pcnt, t1, t2);
        logic [fbhfr_pkg::BYTE_W-1:0] vals [7];
        fbhfr_pkg::t_cfg_idx          idx;
        vals[fbhfr_pkg::CFG_SYNC_FIRST]    = s1;
        vals[fbhfr_pkg::CFG_SYNC_SECOND]   = s2;
        vals[fbhfr_pkg::CFG_FRAME_IDENT]   = fid;
        vals[fbhfr_pkg::CFG_LENGTH_CODE]   = lcode;
        vals[fbhfr_pkg::CFG_PAYLOAD_COUNT] = pcnt & 8'h3F;
        vals[fbhfr_pkg::CFG_TAIL_FIRST]    = t1;
        vals[fbhfr_pkg::CFG_TAIL_SECOND]   = t2;
        idx = idx.first();
        @(negedge i_clk);
        repeat (idx.num()) begin
            i_cfg_valid  = 1'b1;
            i_cfg_index  = idx;
            i_cfg_data   = vals[idx];
            gen_cfg[idx] = vals[idx];
            do @(negedge i_clk); while (!cfg_taken);
            idx = idx.next();
        end
        i_cfg_valid = 1'b0;
    endtask

    task wait_drained();
        do @(negedge i_clk);
        while (accepted_cnt != pushed_cnt || pending_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // drain, then feed non-matching bytes until the parser is back at idle
    task settle_idle();
        logic [fbhfr_pkg::BYTE_W-1:0] fill;
        wait_drained();
        while (rx_phase != fbhfr_pkg::PH_IDLE) begin
            case (rx_phase)
                fbhfr_pkg::PH_SYNC1:
                    fill = differ_from(gen_cfg[fbhfr_pkg::CFG_SYNC_SECOND]);
                fbhfr_pkg::PH_SYNC2:
                    fill = differ_from(gen_cfg[fbhfr_pkg::CFG_FRAME_IDENT]);
                fbhfr_pkg::PH_IDENT:
                    fill = differ_from(gen_cfg[fbhfr_pkg::CFG_LENGTH_CODE]);
                fbhfr_pkg::PH_DATA:
                    fill = (stored_cnt < gen_eff_len())
                           ? 8'($urandom_range(255))
                           : differ_from(gen_cfg[fbhfr_pkg::CFG_TAIL_FIRST]);
                default:
                    fill = differ_from(gen_cfg[fbhfr_pkg::CFG_TAIL_SECOND]);
            endcase
            @(posedge i_clk);
            push_rx(fill);
            wait_drained();
        end
    endtask

    // mostly good frames with random content, some spoilt frames and stray bytes
    task run_random(input int target, input int s_pct, input int r_pct);
        int start;
        int stray;
        int r;
        @(posedge i_clk);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        start = pushed_cnt;
        stray = 0;
        while (pushed_cnt - start - stray < target) begin
            r = $urandom_range(99);
            if (r < 70) begin
                push_frame(FR_GOOD, -1);
            end else if (r < 85) begin
                push_frame(t_frame_kind'($urandom_range(FR_BAD_TAIL2, FR_BAD_SYNC2)), -1);
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    push_rx($urandom_range(1) ? gen_cfg[fbhfr_pkg::CFG_SYNC_FIRST]
                                              : 8'($urandom_range(255)));
                    stray++;
                end
            end
        end
        settle_idle();
    endtask

    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: one-byte payload, register extremes
        write_regs(8'hFF, 8'h00, 8'h80, 8'hFF, 8'd1, 8'h00, 8'hFF);
        @(posedge i_clk);
        push_frame(FR_GOOD, 8'h00);
        push_frame(FR_BAD_TAIL2, 8'hFF);
        push_frame(FR_BAD_TAIL1, 8'h5A);
        // a failed second sync equal to the first sync must not restart the header
        push_rx(8'hFF);
        push_rx(8'hFF);
        push_rx(8'h00);
        settle_idle();

        // zero payload length: commits emit nothing
        write_regs(8'h55, 8'h00, 8'h04, 8'd28, 8'd0, 8'h00, 8'hAA);
        run_random(20, 0, 0);

        // payload count beyond the buffer saturates to the full depth
        write_regs(8'h00, 8'hFF, 8'h7F, 8'h01, 8'd63, 8'hFF, 8'h00);
        @(posedge i_clk);
        send_idle_pct  = 82;
        recv_stall_pct = 0;
        push_frame(FR_GOOD, -1);
        settle_idle();

        // full-depth payload against a slow sink
        write_regs(8'hA5, 8'h5A, 8'h3C, 8'hC3, 8'd32, 8'h81, 8'h7E);
        @(posedge i_clk);
        send_idle_pct  = 0;
        recv_stall_pct = 82;
        push_frame(FR_GOOD, -1);
        settle_idle();

        // sink held off while back-to-back frames keep arriving
        write_regs(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                   8'($urandom_range(255)), 8'd6, 8'($urandom_range(255)),
                   8'($urandom_range(255)));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        holdoff_req    = 1'b1;
        @(posedge i_clk);
        repeat (5) push_frame(FR_GOOD, -1);
        wait (holdoff_done);
        settle_idle();

        // random settings with short payloads under each idling pattern
        for (int m = 0; m < 4; m++) begin
            write_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(255)), 8'($urandom_range(255)),
                       8'($urandom_range(8, 1)), 8'($urandom_range(255)),
                       8'($urandom_range(255)));
            case (m)
                0:       run_random(20, 0, 0);
                1:       run_random(20, 82, 0);
                2:       run_random(20, 0, 82);
                default: run_random(20, 38, 38);
            endcase
        end

        $display("run: %0d bytes received, %0d payload beats checked from %0d frames",
                 accepted_cnt, beat_cnt, frame_cnt);
        $display("     %0d register writes, payload lengths 0 to saturated, %s %0d cycles",
                 cfg_write_cnt, "sink hold-off", HOLDOFF_CYCLES);
        if (error_cnt == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/fbhfr_pkg.sv
rtl/core/four_byte_header_frame_receiver.sv
tb/tb_four_byte_header_frame_receiver.sv
